FILE: hdl/html_char_ref_decoder_macros.svh
// Assertion macros used by the checker of the character reference decoder.
`ifndef HTML_CHAR_REF_DECODER_MACROS_SVH
`define HTML_CHAR_REF_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HCRD_ASSERT_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HCRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must hold on the cycle after any reset edge.
`define HCRD_ASSERT_AFTER_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/hcrd_pkg.sv
// Package with types and constants of the character reference decoder.
`timescale 1ns / 1ps

package hcrd_pkg;

    localparam int HCRD_QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        MODE_TEXT = 3'd0,
        MODE_AMP  = 3'd1,
        MODE_HASH = 3'd2,
        MODE_DEC  = 3'd3,
        MODE_HEX  = 3'd4
    } t_mode;

    // One classified input item: what the back end has to write out, in order.
    typedef struct packed {
        logic        has_amp;
        logic        has_cp;
        logic [31:0] cp;
        logic        has_txt;
        logic [7:0]  txt;
    } t_job;

    localparam logic [7:0] CH_AMP = 8'h26;

    localparam logic [31:0] SURR_LO     = 32'h0000_D800;
    localparam logic [31:0] SURR_HI     = 32'h0000_DFFF;
    localparam logic [31:0] REPLACEMENT = 32'h0000_FFFD;
    localparam logic [31:0] CP_MAX      = 32'h0010_FFFF;

    localparam logic [7:0] UTF8_CONT  = 8'h80;
    localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF8_LEAD4 = 8'hF0;

endpackage

FILE: hdl/hcrd_if.sv
// Valid/ready channel interfaces for input bytes and decoded output bytes.
`timescale 1ns / 1ps

interface hcrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface hcrd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

FILE: hdl/hcrd_front.sv
// Front end: accepts input bytes, tracks the reference parser state and builds jobs.
`timescale 1ns / 1ps

module hcrd_front
    import hcrd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_string,
    input  logic       i_full,
    output logic       o_push,
    output t_job       o_job
);

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;

    t_mode       r_mode, n_mode;
    logic [31:0] r_acc, n_acc;
    t_job        job;
    logic        accept;
    logic        hex_mode;
    logic        dec_ok, hexu_ok, hexl_ok, digit_ok;
    logic [3:0]  dval;
    logic [31:0] acc_base, acc_dig;
    logic        do_text;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && (job.has_amp || job.has_cp || job.has_txt);
    assign o_job   = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_TEXT;
            r_acc  <= '0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
        end
    end

    always_comb begin
        hex_mode = (r_mode == MODE_HEX);
        dec_ok   = (i_in_byte >= CH_0) && (i_in_byte <= CH_9);
        hexu_ok  = (i_in_byte >= CH_A_UP) && (i_in_byte <= CH_F_UP);
        hexl_ok  = (i_in_byte >= CH_A_LO) && (i_in_byte <= CH_F_LO);
        digit_ok = hex_mode ? (dec_ok || hexu_ok || hexl_ok) : dec_ok;
        priority if (dec_ok) begin
            dval = 4'(i_in_byte - CH_0);
        end else if (hexu_ok) begin
            dval = 4'(i_in_byte - CH_A_UP + 8'd10);
        end else begin
            dval = 4'(i_in_byte - CH_A_LO + 8'd10);
        end
        // The accumulator restarts right after "&#".
        acc_base = (r_mode == MODE_HASH) ? '0 : r_acc;
        if (hex_mode) begin
            acc_dig = {acc_base[27:0], 4'h0} + {28'd0, dval};
        end else begin
            acc_dig = {acc_base[28:0], 3'b000} + {acc_base[30:0], 1'b0} + {28'd0, dval};
        end

        n_mode  = r_mode;
        n_acc   = r_acc;
        job     = '0;
        do_text = 1'b0;

        unique case (r_mode)
            MODE_AMP: begin
                if (i_in_byte == CH_HASH) begin
                    n_mode = MODE_HASH;
                end else begin
                    job.has_amp = 1'b1;
                    do_text     = 1'b1;
                end
            end
            MODE_HASH, MODE_DEC, MODE_HEX: begin
                if ((r_mode == MODE_HASH) &&
                    ((i_in_byte == CH_X_LO) || (i_in_byte == CH_X_UP))) begin
                    n_acc  = '0;
                    n_mode = MODE_HEX;
                    if (i_end_of_string) begin
                        job.has_cp = 1'b1;
                        job.cp     = '0;
                    end
                end else if (digit_ok) begin
                    n_acc  = acc_dig;
                    n_mode = hex_mode ? MODE_HEX : MODE_DEC;
                    if (i_end_of_string) begin
                        job.has_cp = 1'b1;
                        job.cp     = acc_dig;
                    end
                end else begin
                    // A non-digit closes the reference; a semicolon is swallowed.
                    job.has_cp = 1'b1;
                    job.cp     = acc_base;
                    n_acc      = '0;
                    if (i_in_byte == CH_SEMI) begin
                        n_mode = MODE_TEXT;
                    end else begin
                        do_text = 1'b1;
                    end
                end
            end
            default: begin
                do_text = 1'b1;
            end
        endcase

        if (do_text) begin
            if (i_in_byte == CH_AMP) begin
                n_mode = MODE_AMP;
            end else begin
                job.has_txt = 1'b1;
                job.txt     = i_in_byte;
                n_mode      = MODE_TEXT;
            end
        end

        if (i_end_of_string) begin
            n_mode = MODE_TEXT;
            n_acc  = '0;
        end
    end

endmodule

FILE: hdl/hcrd_queue.sv
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps

module hcrd_queue
    import hcrd_pkg::*;
#(
    parameter int DEPTH = HCRD_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/hcrd_back.sv
// Back end: expands one job into its output bytes, one byte per cycle while the output is ready.
`timescale 1ns / 1ps

module hcrd_back
    import hcrd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);

    logic        r_valid;
    logic [7:0]  r_byte;
    logic        r_last;
    logic [2:0]  r_idx;

    logic [31:0] cp, sc;
    logic        is1, is2, is3, bad;
    logic [2:0]  ulen, count, j;
    logic [7:0]  ub [4];
    logic [7:0]  sel;
    logic        sel_last, load;

    assign o_valid       = r_valid;
    assign o_out_byte    = r_byte;
    assign o_last_of_run = r_last;

    always_comb begin
        cp  = i_job.cp;
        is1 = (cp[31:7] == '0);
        is2 = (cp[31:11] == '0);
        bad = ((cp >= SURR_LO) && (cp <= SURR_HI)) || (cp > CP_MAX);
        sc  = bad ? REPLACEMENT : cp;
        is3 = (sc[31:16] == '0);

        ub[0] = 8'h00;
        ub[1] = 8'h00;
        ub[2] = 8'h00;
        ub[3] = 8'h00;
        priority if (is1) begin
            ulen  = 3'd1;
            ub[0] = cp[7:0];
        end else if (is2) begin
            ulen  = 3'd2;
            ub[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
            ub[1] = UTF8_CONT | {2'b00, cp[5:0]};
        end else if (is3) begin
            ulen  = 3'd3;
            ub[0] = UTF8_LEAD3 | {4'h0, sc[15:12]};
            ub[1] = UTF8_CONT | {2'b00, sc[11:6]};
            ub[2] = UTF8_CONT | {2'b00, sc[5:0]};
        end else begin
            ulen  = 3'd4;
            ub[0] = UTF8_LEAD4 | {5'b00000, sc[20:18]};
            ub[1] = UTF8_CONT | {2'b00, sc[17:12]};
            ub[2] = UTF8_CONT | {2'b00, sc[11:6]};
            ub[3] = UTF8_CONT | {2'b00, sc[5:0]};
        end

        count = {2'b00, i_job.has_amp} + (i_job.has_cp ? ulen : 3'd0)
              + {2'b00, i_job.has_txt};
        // Position within the encoded code point, past an optional leading ampersand.
        j = r_idx - {2'b00, i_job.has_amp};

        priority if (i_job.has_amp && (r_idx == 3'd0)) begin
            sel = CH_AMP;
        end else if (i_job.has_cp && (j < ulen)) begin
            sel = ub[j[1:0]];
        end else begin
            sel = i_job.txt;
        end
        sel_last = (r_idx == count - 3'd1);

        load  = !r_valid || i_ready;
        o_pop = load && i_valid && sel_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_idx <= sel_last ? 3'd0 : r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_byte <= sel;
            r_last <= sel_last;
        end
    end

endmodule

FILE: hdl/html_char_ref_decoder.sv
// Top level of the HTML numeric character reference to UTF-8 decoder.
//
//  Channel  Dir  Payload                      Handshake
//  i_in     in   in_byte[7:0], end_of_string  valid/ready
//  o_out    out  out_byte[7:0], last_of_run   valid/ready
//
// Plain text bytes flow through at one item per cycle while the output is ready; each is
// registered in the job queue and then in the output register. An item that closes a
// reference yields up to five bytes, which the output register sends one byte per cycle.
// The job queue (QUEUE_DEPTH entries) lets the input keep accepting while the output
// expands a reference or is stalled; input ready drops only when the queue is full.
// Synchronous active-low reset returns the parser to text mode and empties the queue.
`timescale 1ns / 1ps

module html_char_ref_decoder
    import hcrd_pkg::*;
#(
    parameter int QUEUE_DEPTH = HCRD_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hcrd_in_if.sink           i_in,
    hcrd_out_if.source        o_out
);

    logic push, full, q_valid, pop;
    t_job push_job, head_job;

    hcrd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in.valid),
        .o_ready         (i_in.ready),
        .i_in_byte       (i_in.in_byte),
        .i_end_of_string (i_in.end_of_string),
        .i_full          (full),
        .o_push          (push),
        .o_job           (push_job)
    );

    hcrd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .o_valid (q_valid),
        .o_job   (head_job),
        .i_pop   (pop)
    );

    hcrd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_job         (head_job),
        .o_pop         (pop),
        .o_valid       (o_out.valid),
        .i_ready       (o_out.ready),
        .o_out_byte    (o_out.out_byte),
        .o_last_of_run (o_out.last_of_run)
    );

endmodule

FILE: hdl/hcrd_checker.sv
// Port-level checker for the character reference decoder, bound to the top level.
`timescale 1ns / 1ps
`include "html_char_ref_decoder_macros.svh"

module hcrd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    logic       r_seen_in;
    logic [2:0] r_run;
    logic       out_acc;

    assign out_acc = i_out_valid && i_out_ready;

    // Tracks whether any item went in and how long the current output run is.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_in <= 1'b0;
            r_run     <= '0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                r_seen_in <= 1'b1;
            end
            if (out_acc) begin
                r_run <= i_out_last ? 3'd0 : r_run + 3'd1;
            end
        end
    end

    `HCRD_ASSERT_AFTER_RESET(a_no_output_after_reset, !i_out_valid, "output valid right after reset")
    `HCRD_ASSERT_HOLDS(a_output_needs_input, i_out_valid, r_seen_in, "output item with no input item taken")
    `HCRD_ASSERT_HOLDS(a_run_at_most_five, out_acc && !i_out_last, r_run < 3'd4, "output run longer than five items")
    `HCRD_ASSERT_NEXT(a_output_held, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_byte) && $stable(i_out_last), "stalled output item changed")

endmodule

bind html_char_ref_decoder hcrd_checker u_hcrd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last_of_run)
);

FILE: sim/testbench.sv
// Self-checking testbench for the HTML numeric character reference decoder.
`timescale 1ns / 1ps

module testbench
    import hcrd_pkg::*;
();

    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_A_UP = 8'h41;
    localparam logic [7:0] CH_F_UP = 8'h46;
    localparam logic [7:0] CH_A_LO = 8'h61;
    localparam logic [7:0] CH_F_LO = 8'h66;
    localparam logic [7:0] CH_X_UP = 8'h58;
    localparam logic [7:0] CH_X_LO = 8'h78;

    localparam int RANDOM_ITEMS = 470;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_dec_byte;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
        logic       drain_first;
        logic [1:0] level;
    } t_text_item;

    logic clk;
    logic rst_n;

    hcrd_in_if  in_ch();
    hcrd_out_if out_ch();

    html_char_ref_decoder dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Bytes still to be offered, and decoded bytes still awaited.
    t_text_item  text_q[$];
    t_dec_byte   utf8_expect_q[$];
    t_dec_byte   run_q[$];

    // Shadow of the decoder state.
    t_mode       dec_mode = MODE_TEXT;
    logic [31:0] code_acc = '0;

    int unsigned items_taken   = 0;
    int unsigned bytes_checked = 0;
    int unsigned errors        = 0;
    int unsigned run_len_cnt[6];
    int unsigned send_gap      = 0;
    int unsigned stall_left    = 0;
    logic [1:0]  idle_level    = 2'd0;
    logic [1:0]  gen_level     = 2'd0;
    logic        gen_drain     = 1'b0;

    // ---------------------------------------------------------------- prediction

    function automatic void emit(logic [7:0] b);
        t_dec_byte e;
        e.data = b;
        e.last = 1'b0;
        run_q = {run_q, e};
    endfunction

    function automatic void emit_code_point(logic [31:0] cp_in);
        logic [31:0] cp;
        cp = cp_in;
        if (cp < 32'h80) begin
            emit(cp[7:0]);
        end else if (cp < 32'h800) begin
            emit(UTF8_LEAD2 | {3'b0, cp[10:6]});
            emit(UTF8_CONT | {2'b0, cp[5:0]});
        end else begin
            if ((cp >= SURR_LO && cp <= SURR_HI) || cp > CP_MAX)
                cp = REPLACEMENT;
            if (cp < 32'h10000) begin
                emit(UTF8_LEAD3 | {4'b0, cp[15:12]});
                emit(UTF8_CONT | {2'b0, cp[11:6]});
                emit(UTF8_CONT | {2'b0, cp[5:0]});
            end else begin
                emit(UTF8_LEAD4 | {5'b0, cp[20:18]});
                emit(UTF8_CONT | {2'b0, cp[17:12]});
                emit(UTF8_CONT | {2'b0, cp[11:6]});
                emit(UTF8_CONT | {2'b0, cp[5:0]});
            end
        end
    endfunction

    function automatic int digit_value(logic [7:0] b, logic hex);
        if (b >= CH_0 && b <= CH_9) return int'(b - CH_0);
        if (hex && b >= CH_A_UP && b <= CH_F_UP) return int'(b - CH_A_UP) + 10;
        if (hex && b >= CH_A_LO && b <= CH_F_LO) return int'(b - CH_A_LO) + 10;
        return -1;
    endfunction

    function automatic void take_text(logic [7:0] b, logic eos);
        if (b == CH_AMP) begin
            dec_mode = eos ? MODE_TEXT : MODE_AMP;
        end else begin
            emit(b);
            dec_mode = MODE_TEXT;
        end
    endfunction

    function automatic void take_digit(logic [7:0] b, logic eos, logic hex);
        int d;
        d = digit_value(b, hex);
        if (d >= 0) begin
            code_acc = code_acc * (hex ? 32'd16 : 32'd10) + 32'(d);
            dec_mode = hex ? MODE_HEX : MODE_DEC;
            if (eos) begin
                emit_code_point(code_acc);
                dec_mode = MODE_TEXT;
            end
        end else begin
            // A non-digit closes the reference; only a semicolon is swallowed.
            emit_code_point(code_acc);
            code_acc = '0;
            if (b == CH_SEMI)
                dec_mode = MODE_TEXT;
            else
                take_text(b, eos);
        end
    endfunction

    function automatic void predict_decode(logic [7:0] b, logic eos);
        run_q.delete();
        case (dec_mode)
            MODE_AMP: begin
                if (b == CH_HASH) begin
                    dec_mode = eos ? MODE_TEXT : MODE_HASH;
                end else begin
                    emit(CH_AMP);
                    take_text(b, eos);
                end
            end
            MODE_HASH: begin
                code_acc = '0;
                if (b == CH_X_LO || b == CH_X_UP) begin
                    if (eos) begin
                        emit_code_point(32'd0);
                        dec_mode = MODE_TEXT;
                    end else begin
                        dec_mode = MODE_HEX;
                    end
                end else begin
                    take_digit(b, eos, 1'b0);
                end
            end
            MODE_DEC: take_digit(b, eos, 1'b0);
            MODE_HEX: take_digit(b, eos, 1'b1);
            default:  take_text(b, eos);
        endcase
        if (eos) begin
            dec_mode = MODE_TEXT;
            code_acc = '0;
        end
        if (run_q.size() > 0)
            run_q[run_q.size() - 1].last = 1'b1;
        run_len_cnt[run_q.size()]++;
        utf8_expect_q = {utf8_expect_q, run_q};
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic int unsigned pick_gap(logic [1:0] level);
        int unsigned r;
        r = $urandom_range(0, 99);
        case (level)
            2'd0:    return 0;
            2'd1:    return (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3)
                                                    : $urandom_range(8, 30);
            default: return (r < 40) ? 0 : (r < 85) ? $urandom_range(1, 4)
                                                    : $urandom_range(10, 40);
        endcase
    endfunction

    function automatic void add_byte(logic [7:0] b, logic eos);
        t_text_item it;
        it.data        = b;
        it.eos         = eos;
        it.drain_first = gen_drain;
        it.level       = gen_level;
        gen_drain      = 1'b0;
        text_q = {text_q, it};
    endfunction

    function automatic logic [31:0] pick_code_point();
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 32'h7F);
            1: return $urandom_range(32'h80, 32'h7FF);
            2: return $urandom_range(32'h800, 32'hFFFF);
            3: return $urandom_range(SURR_LO, SURR_HI);
            4: return $urandom_range(32'h10000, CP_MAX);
            5: return $urandom_range(CP_MAX + 1, 32'hFFFF_FFFF);
            6: begin
                case ($urandom_range(0, 11))
                    0:  return 32'h0;
                    1:  return 32'h7F;
                    2:  return 32'h80;
                    3:  return 32'h7FF;
                    4:  return 32'h800;
                    5:  return SURR_LO - 1;
                    6:  return SURR_LO;
                    7:  return SURR_HI;
                    8:  return 32'hFFFF;
                    9:  return 32'h10000;
                    10: return CP_MAX;
                    default: return CP_MAX + 1;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [7:0] digit_char(logic [3:0] n, logic hex);
        if (n < 10) return CH_0 + 8'(n);
        if (!hex)   return CH_0;
        return ($urandom_range(0, 1) ? CH_A_UP : CH_A_LO) + 8'(n - 10);
    endfunction

    function automatic void add_number(logic [31:0] v, logic hex);
        logic [7:0]  digs[$];
        int unsigned pad;
        do begin
            if (hex) begin
                digs.push_front(digit_char(v[3:0], 1'b1));
                v = v >> 4;
            end else begin
                digs.push_front(digit_char(4'(v % 10), 1'b0));
                v = v / 10;
            end
        end while (v != 0);
        pad = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        repeat (pad) digs.push_front(CH_0);
        // Now and then append extra digits, so the value can run past 32 bits and the accumulator wrap.
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4))
                digs = {digs, digit_char(4'($urandom_range(0, hex ? 15 : 9)), hex)};
        foreach (digs[i])
            add_byte(digs[i], 1'b0);
    endfunction

    function automatic void add_reference();
        logic hex;
        repeat ($urandom_range(0, 3))
            add_byte(8'($urandom_range(0, 255)), 1'b0);
        add_byte(CH_AMP, 1'b0);
        add_byte(CH_HASH, 1'b0);
        hex = 1'($urandom_range(0, 1));
        if (hex)
            add_byte($urandom_range(0, 1) ? CH_X_LO : CH_X_UP, 1'b0);
        if ($urandom_range(0, 11) != 0)
            add_number(pick_code_point(), hex);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: add_byte(CH_SEMI, 1'b0);
            5:             add_byte(CH_SEMI, 1'b1);
            6:             text_q[text_q.size() - 1].eos = 1'b1;
            7:             add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            8:             add_byte(CH_AMP, $urandom_range(0, 1) == 1);
            default:       ;
        endcase
    endfunction

    function automatic void add_noise();
        logic [7:0] b;
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 7))
                0:       b = CH_AMP;
                1:       b = CH_HASH;
                2:       b = $urandom_range(0, 1) ? CH_X_LO : CH_X_UP;
                3:       b = CH_SEMI;
                4:       b = digit_char(4'($urandom_range(0, 15)), 1'b1);
                default: b = 8'($urandom_range(0, 255));
            endcase
            add_byte(b, $urandom_range(0, 6) == 0);
        end
    endfunction

    // ---------------------------------------------------------------- driver

    always @(posedge clk) begin : drive_proc
        t_text_item nxt;
        if (!rst_n) begin
            in_ch.valid         <= 1'b0;
            in_ch.in_byte       <= '0;
            in_ch.end_of_string <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_decode(in_ch.in_byte, in_ch.end_of_string);
                items_taken++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (text_q.size() == 0 ||
                             (text_q[0].drain_first && utf8_expect_q.size() != 0)) begin
                    in_ch.valid <= 1'b0;
                end else begin
                    nxt = text_q.pop_front();
                    idle_level          = nxt.level;
                    in_ch.valid         <= 1'b1;
                    in_ch.in_byte       <= nxt.data;
                    in_ch.end_of_string <= nxt.eos;
                    send_gap            = pick_gap(nxt.level);
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge clk) begin : check_proc
        t_dec_byte want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                bytes_checked++;
                if (utf8_expect_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected byte: expected none, got %02h last %0b",
                             $time, out_ch.out_byte, out_ch.last_of_run);
                end else begin
                    want = utf8_expect_q.pop_front();
                    if (out_ch.out_byte !== want.data) begin
                        errors++;
                        $display("%0t: out_byte mismatch: expected %02h, got %02h",
                                 $time, want.data, out_ch.out_byte);
                    end
                    if (out_ch.last_of_run !== want.last) begin
                        errors++;
                        $display("%0t: last_of_run mismatch: expected %0b, got %0b",
                                 $time, want.last, out_ch.last_of_run);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                stall_left = pick_gap(idle_level);
            end
        end
    end

    // ---------------------------------------------------------------- control

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int unsigned total;
        rst_n               = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.in_byte       = '0;
        in_ch.end_of_string = 1'b0;
        out_ch.ready        = 1'b0;
        foreach (run_len_cnt[i])
            run_len_cnt[i] = 0;

        // Directed: byte extremes, a lone ampersand and an ampersand-hash at the end,
        // references without digits, a doubled ampersand, a surrogate, a two-byte
        // sequence closed by the end of the string.
        gen_level = 2'd0;
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b1);
        add_byte(CH_AMP, 1'b1);
        add_byte(CH_AMP, 1'b0);
        add_byte(CH_HASH, 1'b1);
        add_byte(CH_AMP, 1'b0);
        add_byte(CH_HASH, 1'b0);
        add_byte(CH_SEMI, 1'b0);
        add_byte(CH_AMP, 1'b0);
        add_byte(CH_HASH, 1'b0);
        add_byte(CH_X_LO, 1'b1);
        add_byte(CH_AMP, 1'b0);
        add_byte(CH_AMP, 1'b0);
        add_byte(CH_HASH, 1'b0);
        add_byte(CH_X_UP, 1'b0);
        add_byte("d", 1'b0);
        add_byte("8", 1'b0);
        add_byte("0", 1'b0);
        add_byte("0", 1'b0);
        add_byte(CH_AMP, 1'b1);
        add_byte(CH_AMP, 1'b0);
        add_byte(CH_HASH, 1'b0);
        add_byte("1", 1'b0);
        add_byte("2", 1'b0);
        add_byte("8", 1'b1);

        // Random: mostly well-formed references, some noise; the idle level
        // cycles between light, none and heavy, and the sender sometimes
        // holds off until the output has drained.
        total = text_q.size() + RANDOM_ITEMS;
        gen_drain = 1'b1;
        while (text_q.size() < total) begin
            case ((text_q.size() / 80) % 3)
                0:       gen_level = 2'd1;
                1:       gen_level = 2'd0;
                default: gen_level = 2'd2;
            endcase
            if ($urandom_range(0, 39) == 0)
                gen_drain = 1'b1;
            if ($urandom_range(0, 9) < 7)
                add_reference();
            else
                add_noise();
        end
        total = text_q.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        do @(negedge clk); while (items_taken != total);
        while (utf8_expect_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d input bytes and %0d output bytes; %0d mismatches.",
                 items_taken, bytes_checked, errors);
        $display("Items by bytes emitted (0..5): %0d %0d %0d %0d %0d %0d",
                 run_len_cnt[0], run_len_cnt[1], run_len_cnt[2],
                 run_len_cnt[3], run_len_cnt[4], run_len_cnt[5]);
        if (errors == 0 && utf8_expect_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
